[design/sls_pkg.sv]
// Shared constants, types and codes for the sorted list select filter.
`default_nettype none
package sls_pkg;
   localparam int STORE_DEPTH  = 32;
   localparam int IDX_W        = $clog2(STORE_DEPTH);
   localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
   localparam int SUM_W        = ((CNT_W > 6) ? CNT_W : 6) + 2;
   localparam int RESULT_LIMIT = 32;
   localparam int DIST_W       = 17;

   localparam logic [2:0] MODE_MIN     = 3'd0;
   localparam logic [2:0] MODE_MAX     = 3'd1;
   localparam logic [2:0] MODE_MAXUP   = 3'd2;
   localparam logic [2:0] MODE_MINUP   = 3'd3;
   localparam logic [2:0] MODE_CLOSEST = 3'd4;
   localparam logic [2:0] MODE_ALL     = 3'd5;

   localparam logic [2:0] REG_SELECT_MODE   = 3'd0;
   localparam logic [2:0] REG_KEEP_COUNT    = 3'd1;
   localparam logic [2:0] REG_THRESHOLD     = 3'd2;
   localparam logic [2:0] REG_BOUNDARY_KEPT = 3'd3;
   localparam logic [2:0] REG_WINDOW_ENABLE = 3'd4;
   localparam logic [2:0] REG_ABOVE_COUNT   = 3'd5;
   localparam logic [2:0] REG_BELOW_COUNT   = 3'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_clr;
      logic scan_step;
      logic fin;
      logic emit_step;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic emit_last;
   } status_type;
endpackage
`default_nettype wire

[design/sorted_list_select_filter.sv]
// Sorted list select filter top level: controller plus datapath.
// Load: one entry per cycle while idle, inserted in sorted place in the insertion row
// (an entry that arrives with the row full is dropped and sets the overflow flag).
// After the last entry: a scan (one row cell per cycle over the single read mux), a
// range step, then one beat per cycle; the next entry is taken at the edge that ends
// the final beat.
`default_nettype none
module sorted_list_select_filter (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [15:0]        req_entry_tag,
   input  wire logic signed [31:0] req_entry_value,
   input  wire logic               req_last_entry,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata,
   output logic                    rsp_valid,
   output logic [15:0]             rsp_out_tag,
   output logic signed [31:0]      rsp_out_value,
   output logic                    rsp_out_last,
   output logic                    rsp_none_kept,
   output logic                    rsp_overflowed
);
   // Synchronous active-high reset clears counts, flags and config to defaults.
   sls_pkg::cmd_type    cmd;
   sls_pkg::status_type status;

   sls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_entry (req_last_entry),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   sls_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .entry_tag      (req_entry_tag),
      .entry_value    (req_entry_value),
      .rsp_valid      (rsp_valid),
      .rsp_out_tag    (rsp_out_tag),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_last   (rsp_out_last),
      .rsp_none_kept  (rsp_none_kept),
      .rsp_overflowed (rsp_overflowed)
   );
endmodule
`default_nettype wire

[design/sls_ctrl.sv]
// Controller state machine: load, scan, range and emit phases.
`default_nettype none
module sls_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                last_entry,
   input  wire sls_pkg::status_type status,
   output sls_pkg::cmd_type         cmd,
   output logic                     busy
);
   sls_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sls_pkg::ST_IDLE: begin
            if (start && last_entry) state_in = sls_pkg::ST_SCAN;
         end
         sls_pkg::ST_SCAN: begin
            if (status.scan_done) state_in = sls_pkg::ST_FIN;
         end
         sls_pkg::ST_FIN: state_in = sls_pkg::ST_EMIT;
         sls_pkg::ST_EMIT: begin
            if (status.emit_last) state_in = sls_pkg::ST_IDLE;
         end
         default: state_in = sls_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         sls_pkg::ST_IDLE: begin
            busy          = 1'b0;
            cmd.load      = start;
            cmd.scan_clr  = start && last_entry;
         end
         sls_pkg::ST_SCAN: cmd.scan_step = !status.scan_done;
         sls_pkg::ST_FIN:  cmd.fin = 1'b1;
         sls_pkg::ST_EMIT: begin
            cmd.emit_step = 1'b1;
            cmd.clear     = status.emit_last;
         end
         default: busy = 1'b1;
      endcase
   end
endmodule
`default_nettype wire

[design/sls_datapath.sv]
// Datapath: config registers, sorted insertion row, scan, range and output registers.
`default_nettype none
module sls_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sls_pkg::cmd_type    cmd,
   output sls_pkg::status_type      status,
   input  wire logic                csr_we,
   input  wire logic [2:0]          csr_index,
   input  wire logic [31:0]         csr_wdata,
   input  wire logic [15:0]         entry_tag,
   input  wire logic signed [31:0]  entry_value,
   output logic                     rsp_valid,
   output logic [15:0]              rsp_out_tag,
   output logic signed [31:0]       rsp_out_value,
   output logic                     rsp_out_last,
   output logic                     rsp_none_kept,
   output logic                     rsp_overflowed
);
   localparam int D  = sls_pkg::STORE_DEPTH;
   localparam int IW = sls_pkg::IDX_W;
   localparam int CW = sls_pkg::CNT_W;
   localparam int SW = sls_pkg::SUM_W;
   localparam int DW = sls_pkg::DIST_W;

   logic [2:0]         mode_ff;
   logic [5:0]         keep_ff, above_ff, below_ff;
   logic signed [31:0] thr_ff;
   logic               bkept_ff, wen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= sls_pkg::MODE_ALL;
         keep_ff  <= 6'd32;
         thr_ff   <= '0;
         bkept_ff <= 1'b1;
         wen_ff   <= 1'b0;
         above_ff <= '0;
         below_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            sls_pkg::REG_SELECT_MODE:   mode_ff  <= csr_wdata[2:0];
            sls_pkg::REG_KEEP_COUNT:    keep_ff  <= csr_wdata[5:0];
            sls_pkg::REG_THRESHOLD:     thr_ff   <= csr_wdata;
            sls_pkg::REG_BOUNDARY_KEPT: bkept_ff <= csr_wdata[0];
            sls_pkg::REG_WINDOW_ENABLE: wen_ff   <= csr_wdata[0];
            sls_pkg::REG_ABOVE_COUNT:   above_ff <= csr_wdata[5:0];
            sls_pkg::REG_BELOW_COUNT:   below_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // insertion row
   logic signed [31:0] val_ff [D];
   logic signed [31:0] val_in [D];
   logic [15:0]        tag_ff [D];
   logic [15:0]        tag_in [D];
   logic [D-1:0]       gt;
   logic [CW-1:0]      count_ff;
   logic               ovf_ff;
   logic               ins;

   assign ins = cmd.load && (count_ff != CW'(D));

   always_comb begin
      for (int i = 0; i < D; i++) begin
         gt[i] = (CW'(i) < count_ff) && (val_ff[i] > entry_value);
      end
   end

   always_comb begin
      for (int i = 0; i < D; i++) begin
         val_in[i] = val_ff[i];
         tag_in[i] = tag_ff[i];
         if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            val_in[i] = val_ff[(i > 0) ? i - 1 : 0];
            tag_in[i] = tag_ff[(i > 0) ? i - 1 : 0];
         end else if (gt[i] || CW'(i) == count_ff) begin
            val_in[i] = entry_value;
            tag_in[i] = entry_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ins) begin
         for (int i = 0; i < D; i++) begin
            val_ff[i] <= val_in[i];
            tag_ff[i] <= tag_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.load) begin
         if (ins) count_ff <= count_ff + CW'(1);
         else     ovf_ff   <= 1'b1;
      end
   end

   // scan over the sorted row
   logic [CW-1:0]      idx_ff, pos_ff, best_ff;
   logic               found_ff;
   logic [DW-1:0]      bestd_ff, scan_dist;
   logic signed [31:0] scan_val;
   logic signed [32:0] diff;
   logic [32:0]        mag;
   logic               hit;

   assign scan_val  = val_ff[idx_ff[IW-1:0]];
   assign diff      = 33'(scan_val) - 33'(thr_ff);
   assign mag       = diff[32] ? 33'(-diff) : 33'(diff);
   assign scan_dist = mag[32:16];

   always_comb begin
      hit = 1'b0;
      case (mode_ff)
         sls_pkg::MODE_MAXUP: hit = bkept_ff ? (scan_val >= thr_ff) : (scan_val > thr_ff);
         sls_pkg::MODE_MINUP: hit = bkept_ff ? (scan_val > thr_ff) : (scan_val >= thr_ff);
         default:             hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_clr) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + CW'(1);
         if (hit && !found_ff) begin
            found_ff <= 1'b1;
            pos_ff   <= idx_ff;
         end
         if (idx_ff == '0 || scan_dist < bestd_ff) begin
            best_ff  <= idx_ff;
            bestd_ff <= scan_dist;
         end
      end
   end

   // range
   logic [SW-1:0] n, k, lo, hi, up, down, best, span, cnt;
   logic [SW-1:0] e_ff, end_ff;
   logic          empty_ff;

   assign n    = SW'(count_ff);
   assign k    = SW'(keep_ff);
   assign best = SW'(best_ff);
   assign up   = wen_ff ? SW'(above_ff) : '0;
   assign down = wen_ff ? SW'(below_ff) : '0;

   always_comb begin
      lo = '0;
      hi = n;
      case (mode_ff)
         sls_pkg::MODE_MIN:   hi = (k < n) ? k : n;
         sls_pkg::MODE_MAX:   lo = (n > k) ? n - k : '0;
         sls_pkg::MODE_MAXUP: lo = found_ff ? SW'(pos_ff) : n;
         sls_pkg::MODE_MINUP: hi = found_ff ? SW'(pos_ff) : n;
         sls_pkg::MODE_CLOSEST: begin
            if (n > SW'(1)) begin
               lo = (best > down) ? best - down : '0;
               hi = (best + up + SW'(1) < n) ? best + up + SW'(1) : n;
            end
         end
         default: ;
      endcase
      span = (hi > lo) ? hi - lo : '0;
      cnt  = (span > SW'(sls_pkg::RESULT_LIMIT)) ? SW'(sls_pkg::RESULT_LIMIT) : span;
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         e_ff     <= lo;
         end_ff   <= lo + cnt;
         empty_ff <= (cnt == '0);
      end else if (cmd.emit_step) begin
         e_ff <= e_ff + SW'(1);
      end
   end

   assign status = '{scan_done: (idx_ff == count_ff),
                     emit_last: (empty_ff || (e_ff + SW'(1) == end_ff))};

   // result beat registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_step) begin
         rsp_out_tag    <= empty_ff ? '0 : tag_ff[e_ff[IW-1:0]];
         rsp_out_value  <= empty_ff ? '0 : val_ff[e_ff[IW-1:0]];
         rsp_out_last   <= status.emit_last;
         rsp_none_kept  <= empty_ff;
         rsp_overflowed <= ovf_ff;
      end
   end
endmodule
`default_nettype wire

[design/sls_checker.sv]
// Port-level checker for the sorted list select filter, with its bind.
`default_nettype none
module sls_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        req_last_entry,
   input wire logic        rsp_valid,
   input wire logic [15:0] rsp_out_tag,
   input wire logic [31:0] rsp_out_value,
   input wire logic        rsp_out_last,
   input wire logic        rsp_none_kept
);
   a_last_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_entry) |=> busy)
      else $error("no busy after last entry");

   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_none_kept) |-> (rsp_out_last && rsp_out_tag == '0
                                       && rsp_out_value == '0))
      else $error("empty beat malformed");

   a_beats_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_last) |=> (rsp_valid && !rsp_none_kept))
      else $error("gap in result beats");

   a_no_beat_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy && !$past(busy)) |-> !rsp_valid)
      else $error("beat while idle");
endmodule

bind sorted_list_select_filter sls_checker u_sls_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_last_entry (req_last_entry),
   .rsp_valid      (rsp_valid),
   .rsp_out_tag    (rsp_out_tag),
   .rsp_out_value  (rsp_out_value),
   .rsp_out_last   (rsp_out_last),
   .rsp_none_kept  (rsp_none_kept)
);
`default_nettype wire
